// ===== hdl/omw_pkg.sv =====
// Shared constants and types for the omni wheel mixer and speed limiter.
// No dependencies; used by every module of the block.
package omw_pkg;

    localparam int VEL_W        = 16;   // signed Q12.4 velocity fields
    localparam int RADIUS_W     = 14;   // unsigned Q6.8 rotation gain
    localparam int SPEED_W      = 16;   // unsigned Q12.4 speed limit
    localparam int WHEEL_W      = 23;   // signed Q.4 wheel target
    localparam int PEAK_W       = WHEEL_W - 1;  // largest positive target, unsigned
    localparam int LANES        = 4;
    localparam int QUOT_W       = WHEEL_W;      // quotient bits, one divider stage each
    localparam int PROD_W       = WHEEL_W + SPEED_W;
    localparam int COEF_W       = 16;
    localparam int CVPROD_W     = VEL_W + COEF_W - 1;
    localparam int RWPROD_W     = VEL_W + RADIUS_W + 1;
    localparam int COEF_SHIFT   = 15;
    localparam int RADIUS_SHIFT = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_ADDR_W   = 2;
    localparam int QUEUE_DEPTH  = 4;

    // 0.707 in Q1.15
    localparam logic signed [COEF_W-1:0] COEF_Q15 = 16'sd23167;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 14'd4608;  // 18.0
    localparam logic [SPEED_W-1:0]  SPEED_RST  = 16'd2880;  // 180.0

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ENABLE       = 2'd0,
        CFG_WHEEL_RADIUS = 2'd1,
        CFG_SPEED_LIMIT  = 2'd2
    } cfg_index_t;

    // Queue entry: four targets (front left lowest) and their positive peak
    typedef struct packed {
        logic [LANES-1:0][WHEEL_W-1:0] target;
        logic [PEAK_W-1:0]             peak;
    } omw_item_t;

endpackage

// ===== hdl/omni_wheel_mix_limit.sv =====
// Top level of the omni wheel mixer with proportional speed limiting.
// Holds the configuration registers; instantiates omw_front, omw_queue, omw_back.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    tdata: vel_x, vel_y, vel_turn
//  m_*       out  m_tvalid/m_tready    tdata: four wheel targets; tuser: was_scaled
//  cfg_*     in   cfg_wr_en            cfg_addr selects register, cfg_wr_data value
//
// One command per cycle sustained while m_tready is high; a command passes five
// mixing stages, the queue, two scaling stages, 23 divider stages and the output
// register. The divider pipeline (one quotient bit per stage) sets the latency.
// Synchronous active-low reset clears all valids and loads default registers.
// m_tready low holds the back part; the queue and the five mixing stages then take
// up to QUEUE_DEPTH + 5 commands before s_tready drops. Commands taken while
// disabled give no transfer.
module omni_wheel_mix_limit #(
    parameter int QUEUE_DEPTH = omw_pkg::QUEUE_DEPTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [47:0]                        s_tdata,   // vel_x, vel_y, vel_turn
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // wheel_front_left, wheel_rear_left, wheel_rear_right, wheel_front_right, 4'b0
    output logic [95:0]                        m_tdata,
    output logic [0:0]                         m_tuser,   // was_scaled
    input  logic                               cfg_wr_en,
    input  logic [omw_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [omw_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    localparam int VW = omw_pkg::VEL_W;
    localparam int WW = omw_pkg::WHEEL_W;

    logic                              enable_reg;
    logic [omw_pkg::RADIUS_W-1:0]      wheel_radius_reg;
    logic [omw_pkg::SPEED_W-1:0]       speed_limit_reg;

    logic                              push, pop, full, empty, scaled;
    omw_pkg::omw_item_t                wr_item, rd_item;
    logic [omw_pkg::LANES-1:0][WW-1:0] wheel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg       <= 1'b0;
            wheel_radius_reg <= omw_pkg::RADIUS_RST;
            speed_limit_reg  <= omw_pkg::SPEED_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                omw_pkg::CFG_ENABLE: begin
                    enable_reg <= cfg_wr_data[0];
                end
                omw_pkg::CFG_WHEEL_RADIUS: begin
                    wheel_radius_reg <= cfg_wr_data[omw_pkg::RADIUS_W-1:0];
                end
                omw_pkg::CFG_SPEED_LIMIT: begin
                    speed_limit_reg <= cfg_wr_data[omw_pkg::SPEED_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    omw_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .vel_x        (s_tdata[VW-1:0]),
        .vel_y        (s_tdata[2*VW-1:VW]),
        .vel_turn     (s_tdata[3*VW-1:2*VW]),
        .enable       (enable_reg),
        .wheel_radius (wheel_radius_reg),
        .queue_full   (full),
        .push         (push),
        .item         (wr_item)
    );

    omw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_item (wr_item),
        .full    (full),
        .pop     (pop),
        .empty   (empty),
        .rd_item (rd_item)
    );

    omw_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (empty),
        .pop         (pop),
        .rd_item     (rd_item),
        .speed_limit (speed_limit_reg),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .wheel       (wheel),
        .was_scaled  (scaled)
    );

    assign m_tdata = {4'b0000, wheel[3], wheel[2], wheel[1], wheel[0]};
    assign m_tuser = scaled;

endmodule

// ===== hdl/omw_front.sv =====
// Front part: accepts velocity commands, mixes them into four wheel targets
// and finds the positive peak. Depends on omw_pkg.
module omw_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [omw_pkg::VEL_W-1:0]     vel_x,
    input  logic signed [omw_pkg::VEL_W-1:0]     vel_y,
    input  logic signed [omw_pkg::VEL_W-1:0]     vel_turn,
    input  logic                                 enable,
    input  logic [omw_pkg::RADIUS_W-1:0]         wheel_radius,
    input  logic                                 queue_full,
    output logic                                 push,
    output omw_pkg::omw_item_t                   item
);

    localparam int WW = omw_pkg::WHEEL_W;
    localparam int L  = omw_pkg::LANES;

    logic                                   adv;
    logic [4:0]                             vld_reg, vld_next;

    logic signed [omw_pkg::VEL_W-1:0]       x_reg, y_reg, w_reg;
    logic [omw_pkg::RADIUS_W-1:0]           rad_reg;
    logic signed [omw_pkg::CVPROD_W-1:0]    cx_prod_reg, cy_prod_reg;
    logic signed [omw_pkg::RWPROD_W-1:0]    rw_prod_reg;
    logic signed [WW-1:0]                   t3_reg [L];
    logic signed [WW-1:0]                   t4_reg [L];
    logic signed [WW-1:0]                   max01_reg, max23_reg;
    logic [L-1:0][WW-1:0]                   t5_reg;
    logic [omw_pkg::PEAK_W-1:0]             peak_reg;

    logic signed [omw_pkg::VEL_W-1:0]       cx, cy;
    logic signed [WW-1:0]                   cx_e, cy_e, rw_e, max_all;

    // whole front moves together; it only waits on the queue
    assign adv     = !vld_reg[4] || !queue_full;
    assign s_ready = adv;
    assign push    = vld_reg[4] && !queue_full;

    // commands arriving while disabled are dropped
    assign vld_next = {vld_reg[3:0], s_valid && enable};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // floor to Q.4 is an arithmetic shift
    assign cx   = cx_prod_reg[omw_pkg::CVPROD_W-1 -: omw_pkg::VEL_W];
    assign cy   = cy_prod_reg[omw_pkg::CVPROD_W-1 -: omw_pkg::VEL_W];
    assign cx_e = WW'(cx);
    assign cy_e = WW'(cy);
    assign rw_e = WW'(rw_prod_reg >>> omw_pkg::RADIUS_SHIFT);

    assign max_all = (max01_reg > max23_reg) ? max01_reg : max23_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg   <= vel_x;
            y_reg   <= vel_y;
            w_reg   <= vel_turn;
            rad_reg <= wheel_radius;

            cx_prod_reg <= omw_pkg::CVPROD_W'(x_reg * omw_pkg::COEF_Q15);
            cy_prod_reg <= omw_pkg::CVPROD_W'(y_reg * omw_pkg::COEF_Q15);
            rw_prod_reg <= omw_pkg::RWPROD_W'(w_reg * $signed({1'b0, rad_reg}));

            t3_reg[0] <= rw_e - cx_e - cy_e;
            t3_reg[1] <= rw_e + cx_e - cy_e;
            t3_reg[2] <= rw_e + cx_e + cy_e;
            t3_reg[3] <= rw_e - cx_e + cy_e;

            for (int i = 0; i < L; i++) begin
                t4_reg[i] <= t3_reg[i];
            end
            max01_reg <= (t3_reg[0] > t3_reg[1]) ? t3_reg[0] : t3_reg[1];
            max23_reg <= (t3_reg[2] > t3_reg[3]) ? t3_reg[2] : t3_reg[3];

            for (int i = 0; i < L; i++) begin
                t5_reg[i] <= t4_reg[i];
            end
            peak_reg <= (max_all > 0) ? max_all[omw_pkg::PEAK_W-1:0] : '0;
        end
    end

    assign item.target = t5_reg;
    assign item.peak   = peak_reg;

endmodule

// ===== hdl/omw_queue.sv =====
// Short queue between the mixing front and the scaling back.
// Depends on omw_pkg for the entry type.
module omw_queue #(
    parameter int DEPTH = omw_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  omw_pkg::omw_item_t wr_item,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output omw_pkg::omw_item_t rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    omw_pkg::omw_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_item = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into full queue");
`endif

endmodule

// ===== hdl/omw_back.sv =====
// Back part: decides scaling; scaled items are multiplied by the limit and
// divided by the peak in a one-bit-per-stage restoring divider, unscaled
// ones by one; then drives the result register. Depends on omw_pkg.
module omw_back (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        queue_empty,
    output logic                                        pop,
    input  omw_pkg::omw_item_t                          rd_item,
    input  logic [omw_pkg::SPEED_W-1:0]                 speed_limit,
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic [omw_pkg::LANES-1:0][omw_pkg::WHEEL_W-1:0] wheel,
    output logic                                        was_scaled
);

    localparam int L  = omw_pkg::LANES;
    localparam int WW = omw_pkg::WHEEL_W;
    localparam int PW = omw_pkg::PEAK_W;
    localparam int QW = omw_pkg::QUOT_W;
    localparam int NW = omw_pkg::PROD_W;

    logic                   en;

    logic                   b1_vld_reg;
    logic                   b1_flag_reg;
    logic [L-1:0]           b1_neg_reg;
    logic [WW-1:0]          b1_mag_reg [L];
    logic [PW-1:0]          b1_div_reg;

    // divider stages: index 0 holds the product, index QW the quotient
    logic [QW:0]            dv_vld_reg;
    logic                   dv_flag_reg [QW+1];
    logic [L-1:0]           dv_neg_reg  [QW+1];
    logic [PW-1:0]          dv_div_reg  [QW+1];
    logic [PW-1:0]          rem_reg     [QW+1][L];
    logic [QW-1:0]          low_reg     [QW+1][L];
    logic [PW-1:0]          rem_next    [QW+1][L];
    logic [QW-1:0]          low_next    [QW+1][L];

    logic [NW-1:0]          prod [L];

    logic                   out_vld_reg;
    logic [L-1:0][WW-1:0]   wheel_reg;
    logic                   flag_reg;

    logic                   scale_now;
    logic [WW-1:0]          tgt;

    assign en  = !out_vld_reg || m_ready;
    assign pop = en && !queue_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_vld_reg  <= 1'b0;
            dv_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            b1_vld_reg  <= pop;
            dv_vld_reg  <= {dv_vld_reg[QW-1:0], b1_vld_reg};
            out_vld_reg <= dv_vld_reg[QW];
        end
    end

    assign scale_now = rd_item.peak > PW'(speed_limit);

    // sign and magnitude split; unscaled items divide by one
    always_ff @(posedge aclk) begin
        if (en) begin
            b1_flag_reg <= scale_now;
            b1_div_reg  <= scale_now ? rd_item.peak : PW'(1);
            for (int i = 0; i < L; i++) begin
                b1_neg_reg[i] <= rd_item.target[i][WW-1];
                b1_mag_reg[i] <= rd_item.target[i][WW-1] ? (WW'(0) - rd_item.target[i])
                                                           : rd_item.target[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < L; i++) begin
            prod[i] = b1_flag_reg ? NW'(b1_mag_reg[i]) * NW'(speed_limit)
                                  : NW'(b1_mag_reg[i]);
        end
    end

    // one quotient bit per stage, lanes side by side
    always_comb begin
        logic [QW-1:0] trial;
        logic          ge;
        for (int s = 0; s <= QW; s++) begin
            for (int i = 0; i < L; i++) begin
                rem_next[s][i] = '0;
                low_next[s][i] = '0;
            end
        end
        for (int s = 1; s <= QW; s++) begin
            for (int i = 0; i < L; i++) begin
                trial = {rem_reg[s-1][i], low_reg[s-1][i][QW-1]};
                ge    = trial >= {1'b0, dv_div_reg[s-1]};
                rem_next[s][i] = ge ? PW'(trial - {1'b0, dv_div_reg[s-1]}) : trial[PW-1:0];
                low_next[s][i] = {low_reg[s-1][i][QW-2:0], ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_flag_reg[0] <= b1_flag_reg;
            dv_neg_reg[0]  <= b1_neg_reg;
            dv_div_reg[0]  <= b1_div_reg;
            for (int i = 0; i < L; i++) begin
                rem_reg[0][i] <= PW'(prod[i][NW-1:QW]);
                low_reg[0][i] <= prod[i][QW-1:0];
            end
            for (int s = 1; s <= QW; s++) begin
                dv_flag_reg[s] <= dv_flag_reg[s-1];
                dv_neg_reg[s]  <= dv_neg_reg[s-1];
                dv_div_reg[s]  <= dv_div_reg[s-1];
                for (int i = 0; i < L; i++) begin
                    rem_reg[s][i] <= rem_next[s][i];
                    low_reg[s][i] <= low_next[s][i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flag_reg <= dv_flag_reg[QW];
            for (int i = 0; i < L; i++) begin
                wheel_reg[i] <= dv_neg_reg[QW][i] ? (WW'(0) - low_reg[QW][i])
                                                  : low_reg[QW][i];
            end
        end
    end

    assign m_valid    = out_vld_reg;
    assign wheel      = wheel_reg;
    assign was_scaled = flag_reg;

    // tgt only feeds the checks below
    assign tgt = WW'(speed_limit);

`ifndef SYNTHESIS
    a_scaled_within_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && flag_reg) |->
            ($signed(wheel_reg[0]) <= $signed(tgt) && $signed(wheel_reg[1]) <= $signed(tgt) &&
             $signed(wheel_reg[2]) <= $signed(tgt) && $signed(wheel_reg[3]) <= $signed(tgt)))
        else $error("scaled wheel target above speed limit");
    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_vld_reg[0] |-> (dv_div_reg[0] != '0))
        else $error("divider started with zero divisor");
`endif

endmodule
